### hw/rtl/kce_pkg.sv
// Shared types, codes and constants for the keyframe curve evaluator.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package kce_pkg;

    localparam int MAX_POINTS = 16;
    localparam int ADDR_W     = $clog2(MAX_POINTS);
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);
    localparam int DIV_STEPS  = 17;
    localparam int STEP_W     = $clog2(DIV_STEPS);

    localparam logic [2:0] ACT_CLEAR      = 3'd0;
    localparam logic [2:0] ACT_ADD        = 3'd1;
    localparam logic [2:0] ACT_SORT       = 3'd2;
    localparam logic [2:0] ACT_EVAL       = 3'd3;
    localparam logic [2:0] ACT_EVAL_CLAMP = 3'd4;

    localparam logic [2:0] EASE_IN     = 3'd1;
    localparam logic [2:0] EASE_OUT    = 3'd2;
    localparam logic [2:0] EASE_IN_OUT = 3'd3;
    localparam logic [2:0] EASE_SMOOTH = 3'd4;
    localparam logic [2:0] EASE_HOLD   = 3'd5;

    localparam logic [1:0] WRAP_CLAMP = 2'd0;
    localparam logic [1:0] WRAP_LOOP  = 2'd1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    localparam logic [16:0] ONE_Q   = 17'd65536;
    localparam logic [18:0] TWO_Q   = 19'd131072;
    localparam logic [17:0] THREE_Q = 18'd196608;
    localparam logic [18:0] FOUR_Q  = 19'd262144;

    typedef struct packed {
        logic [2:0]         action;
        logic signed [23:0] time_q;
        logic signed [31:0] point_value;
        logic [2:0]         ease_mode;
        logic signed [31:0] clamp_low;
        logic signed [31:0] clamp_high;
    } kce_item_t;

    typedef struct packed {
        logic signed [31:0] result_value;
        logic [1:0]         status;
        logic [4:0]         points_held;
    } kce_result_t;

    typedef struct packed {
        logic signed [23:0] key_time;
        logic signed [31:0] key_value;
        logic [2:0]         key_mode;
    } kce_key_t;

    typedef enum logic [1:0] {
        WR_ITEM,
        WR_RD_A,
        WR_RD_B
    } kce_wr_src_t;

    typedef enum logic [2:0] {
        RES_ZERO,
        RES_A,
        RES_B,
        RES_LAST,
        RES_LERP
    } kce_res_sel_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DISPATCH,
        S_SORT_RD,
        S_SORT_CMP,
        S_SORT_W1,
        S_SORT_W2,
        S_EV_ENDS,
        S_EV_ENDS_CHK,
        S_EV_SEG,
        S_EV_SEG_CHK,
        S_EV_DIV,
        S_EV_EASE1,
        S_EV_EASE2,
        S_EV_MUL,
        S_EV_SUM,
        S_EV_CLAMP,
        S_FINISH
    } kce_state_t;

    typedef struct packed {
        logic              load;
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        kce_wr_src_t       wr_src;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_a_addr;
        logic [ADDR_W-1:0] rd_b_addr;
        logic              count_clr;
        logic              count_inc;
        logic              save_last;
        logic              div_init;
        logic              div_step;
        logic              ease1;
        logic              ease2;
        logic              lerp_mul;
        logic              res_en;
        kce_res_sel_t      res_sel;
        logic              clamp;
        logic              set_full;
        logic              set_empty;
        logic              out_load;
    } kce_cmd_t;

    typedef struct packed {
        logic [2:0]       action;
        logic [CNT_W-1:0] count;
        logic             t_le_a;
        logic             t_ge_b;
        logic             t_in_seg;
        logic             seg_zero;
        logic             a_gt_b;
    } kce_stat_t;

endpackage

`default_nettype wire

### hw/rtl/keyframe_curve_evaluator.sv
// Top level of the keyframe curve evaluator: controller plus datapath.
// Depends on kce_pkg, kce_ctrl and kce_datapath.
//
//   channel  | direction | handshake           | beat
//   item     | in        | item_valid/stall    | kce_item_t
//   result   | out       | result_valid/stall  | kce_result_t
//   config   | in        | cfg_we              | cfg_wdata = wrap mode
//
// One item at a time. Clear, add and unused actions go from dispatch to the result
// register. Evaluate reads the end keys and stops at an end, or walks the segments
// over the memory (read, then check), runs the 17-step divider, two easing multiplies
// and the lerp. Sort compares n*(n-1)/2 pairs and swaps each pair found out of order.
// rst_n is asynchronous and clears the state machine, key count and wrap mode.
// A stalled result is held; the next item is taken meanwhile.
`timescale 1ns / 1ps
`default_nettype none

module keyframe_curve_evaluator
    import kce_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        item_valid,
    output logic             item_stall,
    input  wire kce_item_t   item,
    output logic             result_valid,
    input  wire logic        result_stall,
    output kce_result_t      result,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_wdata
);

    kce_cmd_t  cmd;
    kce_stat_t stat;

    kce_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .stat         (stat),
        .cmd          (cmd)
    );

    kce_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .stat      (stat),
        .result    (result)
    );

endmodule

`default_nettype wire

### hw/rtl/kce_datapath.sv
// Datapath: keyframe memory, time wrap, compares, divider, easing and lerp.
// Driven by kce_ctrl through kce_cmd_t; depends on kce_pkg.
`timescale 1ns / 1ps
`default_nettype none

module kce_datapath
    import kce_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire kce_item_t   item,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_wdata,
    input  wire kce_cmd_t    cmd,
    output kce_stat_t        stat,
    output kce_result_t      result
);

    kce_key_t           key_mem [MAX_POINTS];
    kce_item_t          item_reg;
    logic [1:0]         wrap_mode_reg;
    logic [CNT_W-1:0]   count_reg;
    kce_key_t           rd_a_reg;
    kce_key_t           rd_b_reg;
    logic signed [31:0] last_val_reg;
    logic [24:0]        rem_reg;
    logic [23:0]        den_reg;
    logic [16:0]        quo_reg;
    logic [35:0]        mul1_reg;
    logic [16:0]        ease_reg;
    logic signed [50:0] prod_reg;
    logic signed [31:0] res_reg;
    logic [1:0]         status_reg;
    kce_result_t        result_reg;

    logic [23:0]        mag;
    logic [16:0]        t_wrap;
    logic signed [24:0] t_ext;
    logic signed [24:0] ta;
    logic signed [24:0] tb;
    logic signed [24:0] t_diff;
    logic signed [24:0] seg_len;
    logic               div_ge;
    logic [24:0]        div_sub;
    logic [18:0]        ease_f;
    logic [17:0]        smooth_g;
    logic [51:0]        mul2;
    logic [16:0]        ease_next;
    logic signed [32:0] val_diff;
    logic signed [34:0] lerp_q;
    logic signed [35:0] lerp_sum;
    logic signed [31:0] lerp_sat;
    logic signed [31:0] res_next;
    kce_key_t           wr_data;

    always_comb
    begin
        mag    = item_reg.time_q[23] ? 24'(-item_reg.time_q) : item_reg.time_q;
        t_wrap = item_reg.time_q[16:0];
        if (item_reg.time_q[23] || (item_reg.time_q > 24'sd65536))
        begin
            case (wrap_mode_reg)
                WRAP_CLAMP: t_wrap = item_reg.time_q[23] ? 17'd0 : ONE_Q;
                WRAP_LOOP:  t_wrap = {1'b0, item_reg.time_q[15:0]};
                default:    t_wrap = mag[16] ? ONE_Q - {1'b0, item_reg.time_q[15:0]}
                                             : {1'b0, item_reg.time_q[15:0]};
            endcase
        end
        t_ext   = $signed({8'd0, t_wrap});
        ta      = $signed({rd_a_reg.key_time[23], rd_a_reg.key_time});
        tb      = $signed({rd_b_reg.key_time[23], rd_b_reg.key_time});
        t_diff  = t_ext - ta;
        seg_len = tb - ta;
    end

    assign stat.action   = item_reg.action;
    assign stat.count    = count_reg;
    assign stat.t_le_a   = t_ext <= ta;
    assign stat.t_ge_b   = t_ext >= tb;
    assign stat.t_in_seg = (t_ext >= ta) && (t_ext <= tb);
    assign stat.seg_zero = tb <= ta;
    assign stat.a_gt_b   = ta > tb;

    assign div_ge  = rem_reg >= {1'b0, den_reg};
    assign div_sub = div_ge ? rem_reg - {1'b0, den_reg} : rem_reg;

    always_comb
    begin
        case (rd_a_reg.key_mode)
            EASE_OUT:    ease_f = TWO_Q - {2'b0, quo_reg};
            EASE_IN_OUT: ease_f = (quo_reg[16:15] == 2'b00) ? {1'b0, quo_reg, 1'b0}
                                                            : FOUR_Q - {1'b0, quo_reg, 1'b0};
            default:     ease_f = {2'b0, quo_reg};
        endcase
        smooth_g = THREE_Q - {quo_reg, 1'b0};
        mul2     = mul1_reg[33:0] * smooth_g;
        case (rd_a_reg.key_mode) inside
            EASE_IN, EASE_OUT: ease_next = mul1_reg[32:16];
            EASE_IN_OUT:       ease_next = (quo_reg[16:15] == 2'b00) ? mul1_reg[32:16]
                                           : 17'(mul1_reg[33:16] - 18'd65536);
            EASE_SMOOTH:       ease_next = mul2[48:32];
            EASE_HOLD:         ease_next = 17'd0;
            default:           ease_next = quo_reg;
        endcase
    end

    always_comb
    begin
        val_diff = $signed({rd_b_reg.key_value[31], rd_b_reg.key_value})
                 - $signed({rd_a_reg.key_value[31], rd_a_reg.key_value});
        lerp_q   = 35'(prod_reg >>> 16);
        lerp_sum = $signed({{4{rd_a_reg.key_value[31]}}, rd_a_reg.key_value})
                 + $signed({lerp_q[34], lerp_q});
        if (lerp_sum > 36'sd2147483647)
            lerp_sat = 32'sh7fffffff;
        else if (lerp_sum < -36'sd2147483648)
            lerp_sat = 32'sh80000000;
        else
            lerp_sat = lerp_sum[31:0];
        case (cmd.res_sel)
            RES_A:    res_next = rd_a_reg.key_value;
            RES_B:    res_next = rd_b_reg.key_value;
            RES_LAST: res_next = last_val_reg;
            RES_LERP: res_next = lerp_sat;
            default:  res_next = 32'sd0;
        endcase
        case (cmd.wr_src)
            WR_RD_A: wr_data = rd_a_reg;
            WR_RD_B: wr_data = rd_b_reg;
            default: wr_data = '{key_time: item_reg.time_q, key_value: item_reg.point_value,
                                 key_mode: item_reg.ease_mode};
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wrap_mode_reg <= WRAP_CLAMP;
            count_reg     <= '0;
        end
        else
        begin
            if (cfg_we)
                wrap_mode_reg <= cfg_wdata;
            if (cmd.count_clr)
                count_reg <= '0;
            else if (cmd.count_inc)
                count_reg <= count_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
            key_mem[cmd.wr_addr] <= wr_data;
        if (cmd.rd_en)
        begin
            rd_a_reg <= key_mem[cmd.rd_a_addr];
            rd_b_reg <= key_mem[cmd.rd_b_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg   <= item;
            res_reg    <= 32'sd0;
            status_reg <= ST_OK;
        end
        else
        begin
            if (cmd.set_full)
                status_reg <= ST_FULL;
            else if (cmd.set_empty)
                status_reg <= ST_EMPTY;
            if (cmd.res_en)
                res_reg <= res_next;
            else if (cmd.clamp && (item_reg.action == ACT_EVAL_CLAMP))
            begin
                if (res_reg < item_reg.clamp_low)
                    res_reg <= item_reg.clamp_low;
                else if (res_reg > item_reg.clamp_high)
                    res_reg <= item_reg.clamp_high;
            end
        end
        if (cmd.save_last)
            last_val_reg <= rd_b_reg.key_value;
        if (cmd.div_init)
        begin
            rem_reg <= t_diff[24:0];
            den_reg <= seg_len[23:0];
            quo_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= {div_sub[23:0], 1'b0};
            quo_reg <= {quo_reg[15:0], div_ge};
        end
        if (cmd.ease1)
            mul1_reg <= quo_reg * ease_f;
        if (cmd.ease2)
            ease_reg <= ease_next;
        if (cmd.lerp_mul)
            prod_reg <= val_diff * $signed({1'b0, ease_reg});
        if (cmd.out_load)
            result_reg <= '{result_value: res_reg, status: status_reg,
                            points_held: 5'(count_reg)};
    end

    assign result = result_reg;

endmodule

`default_nettype wire

### hw/rtl/kce_ctrl.sv
// Controller: sequences clear, add, sort and evaluate over the datapath.
// Drives kce_datapath through kce_cmd_t; depends on kce_pkg.
`timescale 1ns / 1ps
`default_nettype none

module kce_ctrl
    import kce_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      item_valid,
    output logic           item_stall,
    output logic           result_valid,
    input  wire logic      result_stall,
    input  wire kce_stat_t stat,
    output kce_cmd_t       cmd
);

    localparam int CW1 = CNT_W + 1;

    kce_state_t        state_reg;
    kce_state_t        state_next;
    logic [CNT_W-1:0]  idx_reg;
    logic [CNT_W-1:0]  idx_next;
    logic [CNT_W-1:0]  lim_reg;
    logic [CNT_W-1:0]  lim_next;
    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic              out_valid_reg;
    logic              out_valid_next;

    kce_state_t        adv_state;
    logic [CNT_W-1:0]  adv_idx;
    logic [CNT_W-1:0]  adv_lim;
    logic [CNT_W-1:0]  idx_inc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            lim_reg       <= '0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            lim_reg       <= lim_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign item_stall   = (state_reg != S_IDLE);
    assign result_valid = out_valid_reg;
    assign idx_inc      = idx_reg + 1'b1;

    // advance the bubble sort to the next pair or the next pass, or finish it
    always_comb
    begin
        adv_idx = '0;
        adv_lim = lim_reg;
        if (CW1'(idx_inc) < CW1'(lim_reg))
        begin
            adv_state = S_SORT_RD;
            adv_idx   = idx_inc;
        end
        else if (lim_reg > CNT_W'(1))
        begin
            adv_state = S_SORT_RD;
            adv_lim   = lim_reg - 1'b1;
        end
        else
        begin
            adv_state = S_FINISH;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        lim_next       = lim_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg && result_stall;
        cmd            = '0;
        cmd.rd_a_addr  = ADDR_W'(idx_reg);
        cmd.rd_b_addr  = ADDR_W'(idx_inc);
        cmd.wr_addr    = ADDR_W'(idx_reg);

        unique case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                state_next = S_FINISH;
                case (stat.action) inside
                    ACT_CLEAR: cmd.count_clr = 1'b1;
                    ACT_ADD:
                    begin
                        if (stat.count == CNT_W'(MAX_POINTS))
                            cmd.set_full = 1'b1;
                        else
                        begin
                            cmd.wr_en     = 1'b1;
                            cmd.wr_addr   = ADDR_W'(stat.count);
                            cmd.wr_src    = WR_ITEM;
                            cmd.count_inc = 1'b1;
                        end
                    end
                    ACT_SORT:
                    begin
                        if (stat.count > CNT_W'(1))
                        begin
                            idx_next   = '0;
                            lim_next   = stat.count - 1'b1;
                            state_next = S_SORT_RD;
                        end
                    end
                    ACT_EVAL, ACT_EVAL_CLAMP:
                    begin
                        if (stat.count == '0)
                        begin
                            cmd.set_empty = 1'b1;
                            state_next    = S_EV_CLAMP;
                        end
                        else
                            state_next = S_EV_ENDS;
                    end
                    default: state_next = S_FINISH;
                endcase
            end
            S_SORT_RD:
            begin
                cmd.rd_en  = 1'b1;
                state_next = S_SORT_CMP;
            end
            S_SORT_CMP:
            begin
                if (stat.a_gt_b)
                    state_next = S_SORT_W1;
                else
                begin
                    state_next = adv_state;
                    idx_next   = adv_idx;
                    lim_next   = adv_lim;
                end
            end
            S_SORT_W1:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wr_src = WR_RD_B;
                state_next = S_SORT_W2;
            end
            S_SORT_W2:
            begin
                cmd.wr_en   = 1'b1;
                cmd.wr_addr = ADDR_W'(idx_inc);
                cmd.wr_src  = WR_RD_A;
                state_next  = adv_state;
                idx_next    = adv_idx;
                lim_next    = adv_lim;
            end
            S_EV_ENDS:
            begin
                cmd.rd_en     = 1'b1;
                cmd.rd_a_addr = '0;
                cmd.rd_b_addr = ADDR_W'(stat.count - 1'b1);
                state_next    = S_EV_ENDS_CHK;
            end
            S_EV_ENDS_CHK:
            begin
                cmd.save_last = 1'b1;
                idx_next      = '0;
                if (stat.t_le_a)
                begin
                    cmd.res_en  = 1'b1;
                    cmd.res_sel = RES_A;
                    state_next  = S_EV_CLAMP;
                end
                else if (stat.t_ge_b)
                begin
                    cmd.res_en  = 1'b1;
                    cmd.res_sel = RES_B;
                    state_next  = S_EV_CLAMP;
                end
                else
                    state_next = S_EV_SEG;
            end
            S_EV_SEG:
            begin
                cmd.rd_en  = 1'b1;
                state_next = S_EV_SEG_CHK;
            end
            S_EV_SEG_CHK:
            begin
                if (stat.t_in_seg)
                begin
                    if (stat.seg_zero)
                    begin
                        cmd.res_en  = 1'b1;
                        cmd.res_sel = RES_B;
                        state_next  = S_EV_CLAMP;
                    end
                    else
                    begin
                        cmd.div_init = 1'b1;
                        step_next    = '0;
                        state_next   = S_EV_DIV;
                    end
                end
                else if ((CW1'(idx_reg) + CW1'(2)) < CW1'(stat.count))
                begin
                    idx_next   = idx_inc;
                    state_next = S_EV_SEG;
                end
                else
                begin
                    cmd.res_en  = 1'b1;
                    cmd.res_sel = RES_LAST;
                    state_next  = S_EV_CLAMP;
                end
            end
            S_EV_DIV:
            begin
                cmd.div_step = 1'b1;
                step_next    = step_reg + 1'b1;
                if (step_reg == STEP_W'(DIV_STEPS - 1))
                    state_next = S_EV_EASE1;
            end
            S_EV_EASE1:
            begin
                cmd.ease1  = 1'b1;
                state_next = S_EV_EASE2;
            end
            S_EV_EASE2:
            begin
                cmd.ease2  = 1'b1;
                state_next = S_EV_MUL;
            end
            S_EV_MUL:
            begin
                cmd.lerp_mul = 1'b1;
                state_next   = S_EV_SUM;
            end
            S_EV_SUM:
            begin
                cmd.res_en  = 1'b1;
                cmd.res_sel = RES_LERP;
                state_next  = S_EV_CLAMP;
            end
            S_EV_CLAMP:
            begin
                cmd.clamp  = 1'b1;
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (!out_valid_reg || !result_stall)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule

`default_nettype wire

### hw/rtl/kce_checker.sv
// Port-level checks for the keyframe curve evaluator, bound to the top level.
// Depends on kce_pkg and keyframe_curve_evaluator.
`timescale 1ns / 1ps
`default_nettype none

module kce_checker
    import kce_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        item_valid,
    input wire logic        item_stall,
    input wire logic        result_valid,
    input wire logic        result_stall,
    input wire kce_result_t result
);

    a_busy_after_beat: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall |=> item_stall)
        else $error("item taken while previous beat still in work");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("stalled result changed or dropped");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.status == ST_FULL) |-> result.points_held == 5'(MAX_POINTS))
        else $error("point dropped while table not full");

    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.status == ST_EMPTY) |-> result.points_held == 5'd0)
        else $error("empty status with keys held");

endmodule

bind keyframe_curve_evaluator kce_checker u_kce_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);

`default_nettype wire
